// File: src/cnd_pkg.sv
// Package with shared constants and types for the codebook nibble dot product block.
`timescale 1ns / 1ps

package cnd_pkg;

  localparam int FIELD_BYTES = 16;
  localparam int NUM_LANES = 2 * FIELD_BYTES;
  localparam int WORD_W = 64;
  localparam int BYTE_W = 8;
  localparam int NIBBLE_W = 4;
  localparam int CB_ENTRIES = 16;
  localparam int PROD_W = 16;
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = NUM_LANES / GROUP_SIZE;
  localparam int GROUP_W = 19;
  localparam int CHUNK_W = 21;
  localparam int ACC_W = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int BYTES_PER_CHUNK_DEFAULT = 16;

  localparam logic [WORD_W-1:0] CB_LOW_RESET = 64'hFFFE_FDFC_FBFA_F9F8;
  localparam logic [WORD_W-1:0] CB_HIGH_RESET = 64'h0706_0504_0302_0100;

  localparam logic [CFG_INDEX_W-1:0] REG_CB_LOW = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CB_HIGH = 8'd1;

  typedef logic [CB_ENTRIES-1:0][BYTE_W-1:0] codebook_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0] acts_for_high_nibbles_b;
    logic [WORD_W-1:0] acts_for_high_nibbles_a;
    logic [WORD_W-1:0] acts_for_low_nibbles_b;
    logic [WORD_W-1:0] acts_for_low_nibbles_a;
    logic [WORD_W-1:0] packed_bytes_high;
    logic [WORD_W-1:0] packed_bytes_low;
  } chunk_t;

  typedef logic [NUM_LANES-1:0][PROD_W-1:0] prod_vec_t;

endpackage

// File: src/cnd_channels.sv
// Channel interfaces for chunk input, row sum output and configuration writes.
`timescale 1ns / 1ps

interface cnd_chunk_if;
  logic                        valid;
  logic                        ready;
  logic [cnd_pkg::WORD_W-1:0]  packed_bytes_low;
  logic [cnd_pkg::WORD_W-1:0]  packed_bytes_high;
  logic [cnd_pkg::WORD_W-1:0]  acts_for_low_nibbles_a;
  logic [cnd_pkg::WORD_W-1:0]  acts_for_low_nibbles_b;
  logic [cnd_pkg::WORD_W-1:0]  acts_for_high_nibbles_a;
  logic [cnd_pkg::WORD_W-1:0]  acts_for_high_nibbles_b;
  logic                        last_in_row;

  modport source (
    output valid, packed_bytes_low, packed_bytes_high, acts_for_low_nibbles_a,
           acts_for_low_nibbles_b, acts_for_high_nibbles_a, acts_for_high_nibbles_b,
           last_in_row,
    input  ready
  );
  modport sink (
    input  valid, packed_bytes_low, packed_bytes_high, acts_for_low_nibbles_a,
           acts_for_low_nibbles_b, acts_for_high_nibbles_a, acts_for_high_nibbles_b,
           last_in_row,
    output ready
  );
endinterface

interface cnd_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [cnd_pkg::ACC_W-1:0]  row_sum;

  modport source (output valid, row_sum, input ready);
  modport sink (input valid, row_sum, output ready);
endinterface

interface cnd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cnd_pkg::CFG_INDEX_W-1:0]  index;
  logic [cnd_pkg::WORD_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/cnd_cfg_regs.sv
// Codebook configuration registers written through the configuration channel.
`timescale 1ns / 1ps

module cnd_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  cnd_cfg_if.sink            cfg,
  output cnd_pkg::codebook_t codebook
);

  logic [cnd_pkg::WORD_W-1:0] cb_low;
  logic [cnd_pkg::WORD_W-1:0] cb_high;

  assign cfg.ready = 1'b1;
  assign codebook = {cb_high, cb_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      cb_low  <= cnd_pkg::CB_LOW_RESET;
      cb_high <= cnd_pkg::CB_HIGH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        cnd_pkg::REG_CB_LOW: begin
          cb_low <= cfg.data;
        end
        cnd_pkg::REG_CB_HIGH: begin
          cb_high <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/cnd_mul.sv
// Codebook decode of each nibble in the active bytes and the 32 signed byte products, registered.
`timescale 1ns / 1ps

module cnd_mul #(
  parameter int BYTES_PER_CHUNK = cnd_pkg::BYTES_PER_CHUNK_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  cnd_pkg::stage_ctl_t ctl_in,
  input  cnd_pkg::chunk_t     chunk_in,
  input  cnd_pkg::codebook_t  codebook,
  input  logic                ready_down,
  output logic                ready_up,
  output cnd_pkg::stage_ctl_t ctl_out,
  output cnd_pkg::prod_vec_t  prod
);

  // Bytes past the chunk size contribute nothing; the fields hold at most 16 bytes.
  localparam int ACTIVE_BYTES = (BYTES_PER_CHUNK > cnd_pkg::FIELD_BYTES) ?
                                cnd_pkg::FIELD_BYTES : BYTES_PER_CHUNK;

  logic [cnd_pkg::FIELD_BYTES-1:0][cnd_pkg::BYTE_W-1:0] idx_bytes;
  logic [cnd_pkg::NUM_LANES-1:0][cnd_pkg::BYTE_W-1:0]   acts;
  cnd_pkg::prod_vec_t                                    prod_next;

  assign idx_bytes = {chunk_in.packed_bytes_high, chunk_in.packed_bytes_low};
  assign acts = {chunk_in.acts_for_high_nibbles_b, chunk_in.acts_for_high_nibbles_a,
                 chunk_in.acts_for_low_nibbles_b, chunk_in.acts_for_low_nibbles_a};

  assign ready_up = !ctl_out.valid || ready_down;

  for (genvar lane = 0; lane < cnd_pkg::NUM_LANES; lane++) begin : g_lane
    localparam int BYTE_IDX = lane % cnd_pkg::FIELD_BYTES;
    if (BYTE_IDX < ACTIVE_BYTES) begin : g_on
      logic [cnd_pkg::NIBBLE_W-1:0]      nib;
      logic signed [cnd_pkg::PROD_W-1:0] product;
      if (lane < cnd_pkg::FIELD_BYTES) begin : g_lo
        assign nib = idx_bytes[BYTE_IDX][cnd_pkg::NIBBLE_W-1:0];
      end else begin : g_hi
        assign nib = idx_bytes[BYTE_IDX][cnd_pkg::BYTE_W-1:cnd_pkg::NIBBLE_W];
      end
      assign product = $signed(codebook[nib]) * $signed(acts[lane]);
      assign prod_next[lane] = product;
    end else begin : g_off
      assign prod_next[lane] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (ready_up) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      prod <= prod_next;
    end
  end

endmodule

// File: src/cnd_reduce.sv
// Two registered adder stages: four group sums of eight products, then the chunk sum.
`timescale 1ns / 1ps

module cnd_reduce (
  input  logic                          clk,
  input  logic                          rst,
  input  cnd_pkg::stage_ctl_t           ctl_in,
  input  cnd_pkg::prod_vec_t            prod,
  input  logic                          ready_down,
  output logic                          ready_up,
  output cnd_pkg::stage_ctl_t           ctl_out,
  output logic [cnd_pkg::CHUNK_W-1:0]   chunk_sum
);

  localparam int PROD_EXT = cnd_pkg::GROUP_W - cnd_pkg::PROD_W;
  localparam int GROUP_EXT = cnd_pkg::CHUNK_W - cnd_pkg::GROUP_W;

  cnd_pkg::stage_ctl_t                                   ctl_grp;
  logic [cnd_pkg::NUM_GROUPS-1:0][cnd_pkg::GROUP_W-1:0]  group_sum;
  logic [cnd_pkg::NUM_GROUPS-1:0][cnd_pkg::GROUP_W-1:0]  group_sum_next;
  logic [cnd_pkg::CHUNK_W-1:0]                           chunk_sum_next;
  logic                                                  en_chunk;
  logic                                                  en_group;

  assign en_chunk = !ctl_out.valid || ready_down;
  assign en_group = !ctl_grp.valid || en_chunk;
  assign ready_up = en_group;

  always_comb begin
    for (int g = 0; g < cnd_pkg::NUM_GROUPS; g++) begin
      group_sum_next[g] = '0;
      for (int j = 0; j < cnd_pkg::GROUP_SIZE; j++) begin
        group_sum_next[g] = group_sum_next[g] +
          {{PROD_EXT{prod[g*cnd_pkg::GROUP_SIZE+j][cnd_pkg::PROD_W-1]}},
           prod[g*cnd_pkg::GROUP_SIZE+j]};
      end
    end
  end

  always_comb begin
    chunk_sum_next = '0;
    for (int g = 0; g < cnd_pkg::NUM_GROUPS; g++) begin
      chunk_sum_next = chunk_sum_next +
        {{GROUP_EXT{group_sum[g][cnd_pkg::GROUP_W-1]}}, group_sum[g]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_grp <= '0;
      ctl_out <= '0;
    end else begin
      if (en_group) begin
        ctl_grp <= ctl_in;
      end
      if (en_chunk) begin
        ctl_out <= ctl_grp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_group) begin
      group_sum <= group_sum_next;
    end
    if (en_chunk) begin
      chunk_sum <= chunk_sum_next;
    end
  end

endmodule

// File: src/cnd_acc.sv
// Row accumulator and output register that presents the row sum word.
`timescale 1ns / 1ps

module cnd_acc (
  input  logic                         clk,
  input  logic                         rst,
  input  cnd_pkg::stage_ctl_t          ctl_in,
  input  logic [cnd_pkg::CHUNK_W-1:0]  chunk_sum,
  output logic                         ready_up,
  cnd_result_if.source                 result
);

  localparam int CHUNK_EXT = cnd_pkg::ACC_W - cnd_pkg::CHUNK_W;

  logic [cnd_pkg::ACC_W-1:0] acc;
  logic [cnd_pkg::ACC_W-1:0] acc_next;
  logic [cnd_pkg::ACC_W-1:0] row_sum;
  logic                      out_valid;
  logic                      take;

  // A chunk that closes a row waits here while an unread row sum sits in the output register.
  assign ready_up = !ctl_in.valid || !ctl_in.last || !out_valid || result.ready;
  assign take = ctl_in.valid && ready_up;
  assign acc_next = acc + {{CHUNK_EXT{chunk_sum[cnd_pkg::CHUNK_W-1]}}, chunk_sum};

  assign result.valid = out_valid;
  assign result.row_sum = $signed(row_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        acc <= ctl_in.last ? '0 : acc_next;
      end
      if (take && ctl_in.last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl_in.last) begin
      row_sum <= acc_next;
    end
  end

endmodule

// File: src/codebook_nibble_dot_product_top.sv
// Top level of the codebook nibble dot product block.
// A row-closing chunk passes the input, product, group, chunk and output registers.
// Throughput: one chunk per cycle; the pipeline stalls only when a row sum waits unread
// in the output register and another row-closing chunk reaches the accumulator.
// Reset empties the pipeline and the output register, clears the accumulator and reloads
// the codebook. Configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module codebook_nibble_dot_product_top #(
  parameter int BYTES_PER_CHUNK = cnd_pkg::BYTES_PER_CHUNK_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  cnd_chunk_if.sink    chunk,
  cnd_result_if.source result,
  cnd_cfg_if.sink      cfg
);

  cnd_pkg::stage_ctl_t               ctl_in_reg;
  cnd_pkg::chunk_t                   chunk_reg;
  cnd_pkg::codebook_t                codebook;
  cnd_pkg::stage_ctl_t               ctl_prod;
  cnd_pkg::prod_vec_t                prod;
  cnd_pkg::stage_ctl_t               ctl_sum;
  logic [cnd_pkg::CHUNK_W-1:0]       chunk_sum;
  logic                              mul_ready;
  logic                              reduce_ready;
  logic                              acc_ready;

  assign chunk.ready = !ctl_in_reg.valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_in_reg <= '0;
    end else if (chunk.ready) begin
      ctl_in_reg.valid <= chunk.valid;
      ctl_in_reg.last  <= chunk.last_in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (chunk.ready && chunk.valid) begin
      chunk_reg.packed_bytes_low        <= chunk.packed_bytes_low;
      chunk_reg.packed_bytes_high       <= chunk.packed_bytes_high;
      chunk_reg.acts_for_low_nibbles_a  <= chunk.acts_for_low_nibbles_a;
      chunk_reg.acts_for_low_nibbles_b  <= chunk.acts_for_low_nibbles_b;
      chunk_reg.acts_for_high_nibbles_a <= chunk.acts_for_high_nibbles_a;
      chunk_reg.acts_for_high_nibbles_b <= chunk.acts_for_high_nibbles_b;
    end
  end

  cnd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .codebook (codebook)
  );

  cnd_mul #(
    .BYTES_PER_CHUNK (BYTES_PER_CHUNK)
  ) u_mul (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (ctl_in_reg),
    .chunk_in   (chunk_reg),
    .codebook   (codebook),
    .ready_down (reduce_ready),
    .ready_up   (mul_ready),
    .ctl_out    (ctl_prod),
    .prod       (prod)
  );

  cnd_reduce u_reduce (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (ctl_prod),
    .prod       (prod),
    .ready_down (acc_ready),
    .ready_up   (reduce_ready),
    .ctl_out    (ctl_sum),
    .chunk_sum  (chunk_sum)
  );

  cnd_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_sum),
    .chunk_sum (chunk_sum),
    .ready_up  (acc_ready),
    .result    (result)
  );

endmodule

// File: src/cnd_checker.sv
// Port-level checks for the top level and the bind that attaches them.
`timescale 1ns / 1ps

module cnd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              chunk_valid,
  input logic                              chunk_ready,
  input logic                              chunk_last,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [cnd_pkg::ACC_W-1:0]  row_sum
);

  logic seen_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_last <= 1'b0;
    end else if (chunk_valid && chunk_ready && chunk_last) begin
      seen_last <= 1'b1;
    end
  end

  // A row sum word that is not taken stays on the port unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(row_sum))
    else $error("row sum word changed or dropped while stalled");

  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("row sum word valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> chunk_ready)
    else $error("chunk channel not ready with an empty pipeline");

  // No row sum can appear before some chunk that closes a row went in.
  a_result_needs_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> seen_last)
    else $error("row sum word without any row-closing chunk");

endmodule

bind codebook_nibble_dot_product_top cnd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .chunk_valid  (chunk.valid),
  .chunk_ready  (chunk.ready),
  .chunk_last   (chunk.last_in_row),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .row_sum      (result.row_sum)
);

// File: tb/tb_codebook_nibble_dot_product_top.sv
// Self-checking testbench for the codebook nibble dot product block with random handshakes.
`timescale 1ns / 1ps

module tb_codebook_nibble_dot_product_top;

  localparam int CHUNK_BYTES = cnd_pkg::BYTES_PER_CHUNK_DEFAULT;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_ROW_CHUNKS = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 210;
  localparam logic [cnd_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [cnd_pkg::CFG_INDEX_W-1:0] REG_TOP_INDEX = 8'hFF;
  localparam logic [cnd_pkg::WORD_W-1:0] ALL_MIN = {8{8'h80}};
  localparam logic [cnd_pkg::WORD_W-1:0] ALL_MAX = {8{8'h7F}};
  localparam logic [cnd_pkg::WORD_W-1:0] ALL_ONES = {cnd_pkg::WORD_W{1'b1}};

  typedef logic [cnd_pkg::FIELD_BYTES-1:0][cnd_pkg::BYTE_W-1:0] byte_vec_t;
  typedef logic [cnd_pkg::WORD_W-1:0] word_t;

  typedef struct {
    cnd_pkg::chunk_t body;
    logic            last;
  } chunk_word_t;

  logic clk = 1'b0;
  logic rst;

  cnd_chunk_if  chunk_ch ();
  cnd_result_if sum_ch ();
  cnd_cfg_if    cfg_ch ();

  codebook_nibble_dot_product_top #(
    .BYTES_PER_CHUNK(CHUNK_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .chunk(chunk_ch),
    .result(sum_ch),
    .cfg(cfg_ch)
  );

  cnd_pkg::codebook_t         model_codebook;
  logic [cnd_pkg::ACC_W-1:0]  running_row_sum;
  chunk_word_t                pending_words[$];
  logic [cnd_pkg::ACC_W-1:0]  expected_row_sums[$];
  chunk_word_t                driven_word;
  logic [cnd_pkg::ACC_W-1:0]  want_sum;
  int                         source_gap;
  int                         sink_stall;
  int                         error_count = 0;
  int                         cycle_count = 0;
  bit                         idle_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic word_t random_lane_bytes();
    word_t v;
    case ($urandom_range(0, 9))
      0: v = ALL_MIN;
      1: v = ALL_MAX;
      2: begin
        for (int k = 0; k < 8; k++) v[8*k +: 8] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      end
      3: v = $urandom_range(0, 1) ? ALL_ONES : '0;
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  function automatic word_t pick_codebook(int sel);
    case (sel)
      0: return ALL_MIN;
      1: return ALL_MAX;
      2: return '0;
      3: return ALL_ONES;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic chunk_word_t make_word(word_t pbl, word_t pbh, word_t ala, word_t alb,
                                            word_t aha, word_t ahb, logic last);
    chunk_word_t w;
    w.body.packed_bytes_low = pbl;
    w.body.packed_bytes_high = pbh;
    w.body.acts_for_low_nibbles_a = ala;
    w.body.acts_for_low_nibbles_b = alb;
    w.body.acts_for_high_nibbles_a = aha;
    w.body.acts_for_high_nibbles_b = ahb;
    w.last = last;
    return w;
  endfunction

  function automatic chunk_word_t random_word(logic last);
    return make_word(random_lane_bytes(), random_lane_bytes(), random_lane_bytes(),
                     random_lane_bytes(), random_lane_bytes(), random_lane_bytes(), last);
  endfunction

  function automatic logic [cnd_pkg::ACC_W-1:0] chunk_dot(chunk_word_t w);
    byte_vec_t idx, act_lo, act_hi;
    logic [cnd_pkg::ACC_W-1:0] total;
    int lanes, wt_lo, wt_hi, a_lo, a_hi;
    idx = {w.body.packed_bytes_high, w.body.packed_bytes_low};
    act_lo = {w.body.acts_for_low_nibbles_b, w.body.acts_for_low_nibbles_a};
    act_hi = {w.body.acts_for_high_nibbles_b, w.body.acts_for_high_nibbles_a};
    lanes = (CHUNK_BYTES > cnd_pkg::FIELD_BYTES) ? cnd_pkg::FIELD_BYTES : CHUNK_BYTES;
    total = '0;
    for (int i = 0; i < lanes; i++) begin
      wt_lo = $signed(model_codebook[idx[i][3:0]]);
      wt_hi = $signed(model_codebook[idx[i][7:4]]);
      a_lo = $signed(act_lo[i]);
      a_hi = $signed(act_hi[i]);
      total = total + 32'(wt_lo * a_lo) + 32'(wt_hi * a_hi);
    end
    return total;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [cnd_pkg::CFG_INDEX_W-1:0] idx, input word_t value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == cnd_pkg::REG_CB_LOW) model_codebook[7:0] = value;
    else if (idx == cnd_pkg::REG_CB_HIGH) model_codebook[15:8] = value;
  endtask

  // Sampled away from the rising edge so the driver's updates have all landed.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || chunk_ch.valid || expected_row_sums.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_rows(input int word_total);
    int sent, len, r;
    sent = 0;
    while (sent < word_total) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 3);
      else if (r < 95) len = $urandom_range(4, 12);
      else len = $urandom_range(13, 40);
      for (int j = 0; j < len; j++) pending_words.push_back(random_word(j == len - 1));
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("codebook_nibble_dot_product_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      chunk_ch.valid <= 1'b0;
      source_gap <= 0;
    end else begin
      if (chunk_ch.valid && chunk_ch.ready) begin
        running_row_sum = running_row_sum + chunk_dot(driven_word);
        if (driven_word.last) begin
          expected_row_sums.push_back(running_row_sum);
          running_row_sum = '0;
        end
      end
      if (!chunk_ch.valid || chunk_ch.ready) begin
        if (source_gap != 0) begin
          chunk_ch.valid <= 1'b0;
          source_gap <= source_gap - 1;
        end else if (pending_words.size() != 0) begin
          driven_word = pending_words.pop_front();
          chunk_ch.valid <= 1'b1;
          chunk_ch.packed_bytes_low <= driven_word.body.packed_bytes_low;
          chunk_ch.packed_bytes_high <= driven_word.body.packed_bytes_high;
          chunk_ch.acts_for_low_nibbles_a <= driven_word.body.acts_for_low_nibbles_a;
          chunk_ch.acts_for_low_nibbles_b <= driven_word.body.acts_for_low_nibbles_b;
          chunk_ch.acts_for_high_nibbles_a <= driven_word.body.acts_for_high_nibbles_a;
          chunk_ch.acts_for_high_nibbles_b <= driven_word.body.acts_for_high_nibbles_b;
          chunk_ch.last_in_row <= driven_word.last;
          source_gap <= pick_delay();
        end else begin
          chunk_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sum_ch.ready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (sum_ch.valid && sum_ch.ready) begin
        if (expected_row_sums.size() == 0) begin
          flag_error($sformatf("row sum %0d with none expected", sum_ch.row_sum));
        end else begin
          want_sum = expected_row_sums.pop_front();
          if (sum_ch.row_sum !== want_sum)
            flag_error($sformatf("row_sum got %0d expected %0d", sum_ch.row_sum,
                                 $signed(want_sum)));
        end
      end
      if (sink_stall != 0) begin
        sum_ch.ready <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else begin
        sum_ch.ready <= 1'b1;
        sink_stall <= pick_delay();
      end
    end
  end

  initial begin
    rst = 1'b1;
    chunk_ch.valid = 1'b0;
    chunk_ch.packed_bytes_low = '0;
    chunk_ch.packed_bytes_high = '0;
    chunk_ch.acts_for_low_nibbles_a = '0;
    chunk_ch.acts_for_low_nibbles_b = '0;
    chunk_ch.acts_for_high_nibbles_a = '0;
    chunk_ch.acts_for_high_nibbles_b = '0;
    chunk_ch.last_in_row = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sum_ch.ready = 1'b0;
    model_codebook = {cnd_pkg::CB_HIGH_RESET, cnd_pkg::CB_LOW_RESET};
    running_row_sum = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Codebook as it comes out of reset, every entry reached at least once.
    pending_words.push_back(make_word('0, '0, '0, '0, '0, '0, 1'b1));
    pending_words.push_back(make_word('0, '0, ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX, 1'b1));
    pending_words.push_back(make_word(ALL_ONES, ALL_ONES, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN,
                                      1'b1));
    pending_words.push_back(make_word(64'hEFCD_AB89_6745_2301, 64'h1032_5476_98BA_DCFE,
                                      64'h0102_0304_0506_0708, 64'hF9FA_FBFC_FDFE_FF80,
                                      64'h7F10_2030_4050_6070, 64'h8090_A0B0_C0D0_E0F0, 1'b1));
    pending_words.push_back(make_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                      ALL_ONES, 1'b1));
    for (int j = 0; j < 3; j++) pending_words.push_back(random_word(j == 2));
    settle();

    // Extreme codebook entries against extreme activations.
    write_reg(cnd_pkg::REG_CB_LOW, ALL_MIN);
    write_reg(cnd_pkg::REG_CB_HIGH, ALL_MAX);
    pending_words.push_back(make_word('0, '0, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN, 1'b1));
    pending_words.push_back(make_word(ALL_ONES, ALL_ONES, ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN,
                                      1'b0));
    pending_words.push_back(make_word({8{8'hF0}}, {8{8'h0F}}, ALL_MAX, ALL_MIN, ALL_MAX,
                                      ALL_MIN, 1'b0));
    pending_words.push_back(random_word(1'b1));
    settle();

    // Writes to indexes beyond the two codebook registers must leave the codebook alone.
    write_reg(REG_UNMAPPED, {$urandom(), $urandom()});
    write_reg(REG_TOP_INDEX, ALL_ONES);
    for (int j = 0; j < 3; j++) pending_words.push_back(random_word(1'b1));
    settle();

    // One long row of maximal positive chunks.
    write_reg(cnd_pkg::REG_CB_HIGH, ALL_MIN);
    for (int j = 0; j < LONG_ROW_CHUNKS; j++)
      pending_words.push_back(make_word({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                        ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN,
                                        j == LONG_ROW_CHUNKS - 1));
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(cnd_pkg::REG_CB_LOW, pick_codebook(p < 4 ? p : $urandom_range(0, 7)));
      write_reg(cnd_pkg::REG_CB_HIGH,
                pick_codebook(p < 4 ? (p + 2) % 4 : $urandom_range(0, 7)));
      idle_off = (p == 2);
      if (p == 3) begin
        queue_random_rows(WORDS_PER_PHASE / 2);
        wait_drained();
        queue_random_rows(WORDS_PER_PHASE / 2);
      end else begin
        queue_random_rows(WORDS_PER_PHASE);
      end
      settle();
    end
    idle_off = 1'b0;

    if (error_count == 0) begin
      $display("codebook_nibble_dot_product_top test passed");
    end else begin
      $display("codebook_nibble_dot_product_top test failed");
    end
    $finish;
  end

endmodule
